/* rtl/bmhpq_pkg.sv */
package bmhpq_pkg;

    // Operation codes of an input item.
    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    // Status codes of a result item.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Field widths fixed by the interface.
    localparam int KEY_W   = 8;
    localparam int TAG_W   = 32;
    localparam int COUNT_W = 7;

    // One heap slot as it is kept in memory.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_EX_ROOT,
        ST_EX_LAST,
        ST_EX_TAKE,
        ST_DN_LEFT,
        ST_DN_RIGHT,
        ST_DN_CMP,
        ST_FIN
    } t_state;

endpackage

/* rtl/bmhpq_ram.sv */
module bmhpq_ram
    import bmhpq_pkg::*;
#(
    parameter int WIDTH = 40,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/binary_max_heap_priority_queue.sv */
// Channel | Direction | Handshake                | Fields
// in      | input     | i_in_valid / o_in_stall  | i_operation, i_urgency, i_payload_tag
// out     | output    | o_out_valid / i_out_stall| o_status, o_out_urgency, o_out_payload,
//         |           |                          | o_entry_count
//
// An insert or an extract takes longer the more levels its entry moves. The heap memory
// gives one registered read per cycle.
// Reset is synchronous and active low; it empties the heap and drops any result.
// A new item is taken while a result is stalled at the output; the next result waits.
module binary_max_heap_priority_queue
    import bmhpq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic [KEY_W-1:0]   i_urgency,
    input  logic [TAG_W-1:0]   i_payload_tag,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic [KEY_W-1:0]   o_out_urgency,
    output logic [TAG_W-1:0]   o_out_payload,
    output logic [COUNT_W-1:0] o_entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    t_state r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_pos, n_pos;
    t_entry             r_item, n_item;
    t_entry             r_left, n_left;
    logic               r_rvalid, n_rvalid;
    logic [1:0]         r_status, n_status;
    t_entry             r_res, n_res;
    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_out_status, n_out_status;
    t_entry             r_out_res, n_out_res;
    logic [COUNT_W-1:0] r_out_count, n_out_count;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    logic [AW-1:0] rd_addr;
    t_entry        rd_data;
    logic [ENTRY_W-1:0] rd_raw;

    logic [AW-1:0]         parent;
    logic [CW-1:0]         last_idx;
    logic [IW-1:0]         left_i, right_i, count_i, cand_i;
    logic                  take_right;
    t_entry                cand;
    logic [CW+COUNT_W-1:0] count_ext;

    bmhpq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CAPACITY)
    ) u_heap (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_raw)
    );

    assign rd_data = t_entry'(rd_raw);

    // Tree index arithmetic around the current hole.
    assign parent    = (r_pos - 1'b1) >> 1;
    assign last_idx  = r_count - 1'b1;
    assign left_i    = {1'b0, r_pos, 1'b1};
    assign right_i   = left_i + 1'b1;
    assign count_i   = IW'(r_count);
    assign count_ext = {{COUNT_W{1'b0}}, r_count};

    // Larger child; the left child wins a tie.
    assign take_right = r_rvalid && (rd_data.key > r_left.key);
    assign cand       = take_right ? rd_data : r_left;
    assign cand_i     = take_right ? right_i : left_i;

    // State and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_item       <= n_item;
        r_left       <= n_left;
        r_rvalid     <= n_rvalid;
        r_status     <= n_status;
        r_res        <= n_res;
        r_out_status <= n_out_status;
        r_out_res    <= n_out_res;
        r_out_count  <= n_out_count;
    end

    // Sequencer: next state, memory accesses and result loading.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_pos        = r_pos;
        n_item       = r_item;
        n_left       = r_left;
        n_rvalid     = r_rvalid;
        n_status     = r_status;
        n_res        = r_res;
        n_out_status = r_out_status;
        n_out_res    = r_out_res;
        n_out_count  = r_out_count;
        n_out_valid  = r_out_valid && i_out_stall;
        wr_en        = 1'b0;
        wr_addr      = r_pos;
        wr_data      = r_item;
        rd_addr      = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item.key = i_urgency;
                    n_item.tag = i_payload_tag;
                    n_res      = '0;
                    n_status   = STATUS_OK;
                    if (i_operation == OP_INSERT) begin
                        if (r_count == CAP_CNT) begin
                            n_status = STATUS_FULL;
                            n_state  = ST_FIN;
                        end else begin
                            n_pos   = r_count[AW-1:0];
                            n_count = r_count + 1'b1;
                            n_state = ST_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = STATUS_EMPTY;
                            n_state  = ST_FIN;
                        end else begin
                            n_state = ST_EX_ROOT;
                        end
                    end
                end
            end

            // Sift up: read the parent of the hole, or place the entry at the root.
            ST_UP_RD: begin
                if (r_pos == '0) begin
                    wr_en   = 1'b1;
                    n_state = ST_FIN;
                end else begin
                    rd_addr = parent;
                    n_state = ST_UP_CMP;
                end
            end

            // A smaller parent moves down into the hole.
            ST_UP_CMP: begin
                wr_en = 1'b1;
                if (rd_data.key < r_item.key) begin
                    wr_data = rd_data;
                    n_pos   = parent;
                    n_state = ST_UP_RD;
                end else begin
                    n_state = ST_FIN;
                end
            end

            ST_EX_ROOT: begin
                rd_addr = '0;
                n_state = ST_EX_LAST;
            end

            // The root becomes the result; fetch the last entry.
            ST_EX_LAST: begin
                n_res   = rd_data;
                rd_addr = last_idx[AW-1:0];
                n_count = last_idx;
                n_state = ST_EX_TAKE;
            end

            // The last entry is carried down from a hole at the root.
            ST_EX_TAKE: begin
                n_item = rd_data;
                n_pos  = '0;
                if (r_count == '0) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_DN_LEFT;
                end
            end

            ST_DN_LEFT: begin
                if (left_i < count_i) begin
                    rd_addr = left_i[AW-1:0];
                    n_state = ST_DN_RIGHT;
                end else begin
                    wr_en   = 1'b1;
                    n_state = ST_FIN;
                end
            end

            ST_DN_RIGHT: begin
                n_left   = rd_data;
                n_rvalid = right_i < count_i;
                if (right_i < count_i) begin
                    rd_addr = right_i[AW-1:0];
                end
                n_state = ST_DN_CMP;
            end

            // A larger child moves up into the hole.
            ST_DN_CMP: begin
                wr_en = 1'b1;
                if (cand.key > r_item.key) begin
                    wr_data = cand;
                    n_pos   = cand_i[AW-1:0];
                    n_state = ST_DN_LEFT;
                end else begin
                    n_state = ST_FIN;
                end
            end

            // Hand the result to the output register once it is free.
            ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_res    = r_res;
                    n_out_count  = count_ext[COUNT_W-1:0];
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall    = (r_state != ST_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_out_urgency = r_out_res.key;
    assign o_out_payload = r_out_res.tag;
    assign o_entry_count = r_out_count;

    // The stored count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("entry count exceeds capacity");

    // A new result appears only out of the finishing state.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_FIN))
        else $error("result loaded outside the finishing state");

    // While sifting down, the hole stays inside the live part of the heap.
    a_hole_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DN_LEFT || r_state == ST_DN_RIGHT || r_state == ST_DN_CMP)
        |-> (IW'(r_pos) < count_i))
        else $error("sift-down hole beyond entry count");

    // A result that is not an ok extract carries zero fields.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != STATUS_OK) |-> (r_out_res == '0))
        else $error("nonzero fields on a full or empty result");

endmodule

/* sim/binary_max_heap_priority_queue_tb.sv */
module binary_max_heap_priority_queue_tb;
    import bmhpq_pkg::*;

    localparam int HEAP_DEPTH  = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_GAP     = 13;
    localparam int DRAIN_WAIT  = 40;
    localparam int NUM_ROWS    = 24;

    // One result as the output channel presents it.
    typedef struct packed {
        logic [1:0]         status;
        logic [KEY_W-1:0]   urgency;
        logic [TAG_W-1:0]   payload;
        logic [COUNT_W-1:0] count;
    } t_heap_result;

    // One directed operation. When has_value is set, the result is given in the row.
    typedef struct packed {
        logic               op;
        logic [KEY_W-1:0]   key;
        logic [TAG_W-1:0]   tag;
        logic               has_value;
        logic [1:0]         status;
        logic [KEY_W-1:0]   urgency;
        logic [TAG_W-1:0]   payload;
        logic [COUNT_W-1:0] count;
    } t_directed_row;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_stall;
    logic               i_operation   = OP_INSERT;
    logic [KEY_W-1:0]   i_urgency     = '0;
    logic [TAG_W-1:0]   i_payload_tag = '0;
    logic               o_out_valid;
    logic               i_out_stall   = 1'b0;
    logic [1:0]         o_status;
    logic [KEY_W-1:0]   o_out_urgency;
    logic [TAG_W-1:0]   o_out_payload;
    logic [COUNT_W-1:0] o_entry_count;

    // Shadow copy of the heap used to predict every result.
    logic [KEY_W-1:0] shadow_key [HEAP_DEPTH];
    logic [TAG_W-1:0] shadow_tag [HEAP_DEPTH];
    int               shadow_count = 0;

    t_heap_result pending_results[$];

    int  faults          = 0;
    int  ops_sent        = 0;
    int  results_checked = 0;
    int  full_seen       = 0;
    int  empty_seen      = 0;
    int  cycle_count     = 0;
    int  out_hold_cycles = 0;
    int  stall_left      = 0;
    bit  send_calm       = 1'b0;
    bit  recv_calm       = 1'b0;

    // Directed operations: empty and full-range extremes, equal keys, tie on children.
    t_directed_row directed_rows [NUM_ROWS] = '{
        '{OP_EXTRACT, 8'd0,   32'h0000_0000, 1'b1, STATUS_EMPTY, 8'd0,   32'h0000_0000, 7'd0},
        '{OP_INSERT,  8'd255, 32'hFFFF_FFFF, 1'b1, STATUS_OK,    8'd0,   32'h0000_0000, 7'd1},
        '{OP_EXTRACT, 8'd0,   32'h0000_0000, 1'b1, STATUS_OK,    8'd255, 32'hFFFF_FFFF, 7'd0},
        '{OP_EXTRACT, 8'd0,   32'h0000_0000, 1'b1, STATUS_EMPTY, 8'd0,   32'h0000_0000, 7'd0},
        '{OP_INSERT,  8'd0,   32'h0000_0000, 1'b1, STATUS_OK,    8'd0,   32'h0000_0000, 7'd1},
        '{OP_INSERT,  8'd0,   32'h5555_5555, 1'b1, STATUS_OK,    8'd0,   32'h0000_0000, 7'd2},
        '{OP_EXTRACT, 8'd0,   32'h0000_0000, 1'b1, STATUS_OK,    8'd0,   32'h0000_0000, 7'd1},
        '{OP_EXTRACT, 8'd0,   32'h0000_0000, 1'b1, STATUS_OK,    8'd0,   32'h5555_5555, 7'd0},
        '{OP_INSERT,  8'd7,   32'h0000_0A01, 1'b0, STATUS_OK,    8'd0,   32'h0000_0000, 7'd0},
        '{OP_INSERT,  8'd7,   32'h0000_0A02, 1'b0, STATUS_OK,    8'd0,   32'h0000_0000, 7'd0},
        '{OP_INSERT,  8'd7,   32'h0000_0A03, 1'b0, STATUS_OK,    8'd0,   32'h0000_0000, 7'd0},
        '{OP_INSERT,  8'd9,   32'h0000_0B01, 1'b0, STATUS_OK,    8'd0,   32'h0000_0000, 7'd0},
        '{OP_INSERT,  8'd7,   32'h0000_0A04, 1'b0, STATUS_OK,    8'd0,   32'h0000_0000, 7'd0},
        '{OP_EXTRACT, 8'd0,   32'h0000_0000, 1'b0, STATUS_OK,    8'd0,   32'h0000_0000, 7'd0},
        '{OP_EXTRACT, 8'd0,   32'h0000_0000, 1'b0, STATUS_OK,    8'd0,   32'h0000_0000, 7'd0},
        '{OP_EXTRACT, 8'd0,   32'h0000_0000, 1'b0, STATUS_OK,    8'd0,   32'h0000_0000, 7'd0},
        '{OP_EXTRACT, 8'd0,   32'h0000_0000, 1'b0, STATUS_OK,    8'd0,   32'h0000_0000, 7'd0},
        '{OP_EXTRACT, 8'd0,   32'h0000_0000, 1'b0, STATUS_OK,    8'd0,   32'h0000_0000, 7'd0},
        '{OP_EXTRACT, 8'd0,   32'h0000_0000, 1'b1, STATUS_EMPTY, 8'd0,   32'h0000_0000, 7'd0},
        '{OP_INSERT,  8'd128, 32'hAAAA_AAAA, 1'b0, STATUS_OK,    8'd0,   32'h0000_0000, 7'd0},
        '{OP_INSERT,  8'd1,   32'h0000_0001, 1'b0, STATUS_OK,    8'd0,   32'h0000_0000, 7'd0},
        '{OP_INSERT,  8'd254, 32'h8000_0000, 1'b0, STATUS_OK,    8'd0,   32'h0000_0000, 7'd0},
        '{OP_EXTRACT, 8'd0,   32'h0000_0000, 1'b0, STATUS_OK,    8'd0,   32'h0000_0000, 7'd0},
        '{OP_EXTRACT, 8'd0,   32'h0000_0000, 1'b0, STATUS_OK,    8'd0,   32'h0000_0000, 7'd0}
    };

    binary_max_heap_priority_queue #(
        .CAPACITY(HEAP_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_urgency    (i_urgency),
        .i_payload_tag(i_payload_tag),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_out_urgency(o_out_urgency),
        .o_out_payload(o_out_payload),
        .o_entry_count(o_entry_count)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Exchange two slots of the shadow heap.
    function automatic void swap_slots(input int a, input int b);
        logic [KEY_W-1:0] k;
        logic [TAG_W-1:0] t;
        k = shadow_key[a];
        t = shadow_tag[a];
        shadow_key[a] = shadow_key[b];
        shadow_tag[a] = shadow_tag[b];
        shadow_key[b] = k;
        shadow_tag[b] = t;
    endfunction

    // Apply one operation to the shadow heap and return the result it should give.
    function automatic t_heap_result heap_apply(input logic op, input logic [KEY_W-1:0] key,
                                                input logic [TAG_W-1:0] tag);
        t_heap_result res;
        int pos;
        int best;
        int left;
        int right;
        res = '0;
        res.status = STATUS_OK;
        if (op == OP_INSERT) begin
            if (shadow_count >= HEAP_DEPTH) begin
                res.status = STATUS_FULL;
            end else begin
                // Place at the end and move up while the parent is strictly smaller.
                pos = shadow_count;
                shadow_key[pos] = key;
                shadow_tag[pos] = tag;
                while (pos > 0 && shadow_key[(pos - 1) / 2] < shadow_key[pos]) begin
                    swap_slots(pos, (pos - 1) / 2);
                    pos = (pos - 1) / 2;
                end
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = STATUS_EMPTY;
            end else begin
                res.urgency = shadow_key[0];
                res.payload = shadow_tag[0];
                shadow_count--;
                shadow_key[0] = shadow_key[shadow_count];
                shadow_tag[0] = shadow_tag[shadow_count];
                // Move the new root down toward the larger child; the left one wins ties.
                pos = 0;
                while (pos < shadow_count) begin
                    best = pos;
                    left = 2 * pos + 1;
                    right = 2 * pos + 2;
                    if (left < shadow_count && shadow_key[left] > shadow_key[best]) begin
                        best = left;
                    end
                    if (right < shadow_count && shadow_key[right] > shadow_key[best]) begin
                        best = right;
                    end
                    if (best == pos) begin
                        break;
                    end
                    swap_slots(pos, best);
                    pos = best;
                end
            end
        end
        res.count = shadow_count[COUNT_W-1:0];
        return res;
    endfunction

    // Offer one operation after a random gap (none while send_calm is set) and hold it until the transfer.
    task automatic offer_op(input logic op, input logic [KEY_W-1:0] key,
                            input logic [TAG_W-1:0] tag, input bit has_value,
                            input t_heap_result given);
        int gap;
        t_heap_result predicted;
        gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_urgency     <= key;
        i_payload_tag <= tag;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predicted = heap_apply(op, key, tag);
        pending_results.push_back(has_value ? given : predicted);
        ops_sent++;
    endtask

    // Stop offering and wait until every outstanding result has been transferred.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Draw a key: full range, a narrow range that makes ties likely, or an extreme or its neighbour.
    function automatic logic [KEY_W-1:0] pick_key(input int mode);
        logic [KEY_W-1:0] k;
        case (mode)
            0: k = KEY_W'($urandom_range(0, 255));
            1: k = KEY_W'($urandom_range(0, 3));
            default: begin
                k = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                if ($urandom_range(0, 3) == 0) begin
                    k = k ^ 8'd1;
                end
            end
        endcase
        return k;
    endfunction

    // Compare one output transfer with the oldest prediction.
    task automatic check_result();
        t_heap_result want;
        t_heap_result got;
        got = {o_status, o_out_urgency, o_out_payload, o_entry_count};
        if (pending_results.size() == 0) begin
            faults++;
            if (faults <= 10) begin
                $display("unexpected result: status=%0d urgency=%0d payload=%h count=%0d",
                         got.status, got.urgency, got.payload, got.count);
            end
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        if (got.status == STATUS_FULL) begin
            full_seen++;
        end
        if (got.status == STATUS_EMPTY) begin
            empty_seen++;
        end
        if (got.status !== want.status || got.urgency !== want.urgency ||
            got.payload !== want.payload || got.count !== want.count) begin
            faults++;
            if (faults <= 10) begin
                $display("result %0d mismatch: expected status=%0d urgency=%0d payload=%h count=%0d",
                         results_checked, want.status, want.urgency, want.payload, want.count);
                $display("                   actual   status=%0d urgency=%0d payload=%h count=%0d",
                         got.status, got.urgency, got.payload, got.count);
            end
        end
    endtask

    // Output side: check each transfer, then stall for a random while, or not at all while
    // recv_calm is set. A requested hold keeps the stall up for a long stretch.
    always @(posedge i_clk) begin
        if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            check_result();
            stall_left = recv_calm ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (out_hold_cycles > 0) begin
            stall_left = out_hold_cycles;
            out_hold_cycles = 0;
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int ins_pct;
        int key_mode;
        logic op;
        t_heap_result given;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        for (int r = 0; r < NUM_ROWS; r++) begin
            given = {directed_rows[r].status, directed_rows[r].urgency,
                     directed_rows[r].payload, directed_rows[r].count};
            offer_op(directed_rows[r].op, directed_rows[r].key, directed_rows[r].tag,
                     directed_rows[r].has_value, given);
        end
        wait_for_drain();

        // Fill past capacity while the output is held off, so the input stalls too.
        send_calm = 1'b1;
        out_hold_cycles = 400;
        for (int n = 0; n < 70; n++) begin
            offer_op(OP_INSERT, pick_key(0), $urandom, 1'b0, '0);
        end
        send_calm = 1'b0;
        wait_for_drain();

        // Empty the heap and go past it.
        for (int n = 0; n < 70; n++) begin
            offer_op(OP_EXTRACT, pick_key(0), $urandom, 1'b0, '0);
        end

        // Random segments with shifting insert bias and key spread.
        for (int seg = 0; seg < 12; seg++) begin
            case (seg % 6)
                0: ins_pct = 90;
                1: ins_pct = 15;
                2: ins_pct = 55;
                3: ins_pct = 75;
                4: ins_pct = 30;
                default: ins_pct = 50;
            endcase
            key_mode = seg % 3;
            send_calm = (seg == 5);
            recv_calm = (seg == 5);
            for (int n = 0; n < 100; n++) begin
                op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_EXTRACT;
                offer_op(op, pick_key(key_mode), $urandom, 1'b0, '0);
            end
        end
        send_calm = 1'b0;
        recv_calm = 1'b0;

        wait_for_drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Ran %0d heap operations and checked %0d results, including %0d full inserts",
                 ops_sent, results_checked, full_seen);
        $display("and %0d empty extracts, equal-key ties and a long output hold; %0d faults.",
                 empty_seen, faults);
        if (faults == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* binary_max_heap_priority_queue.f */
rtl/bmhpq_pkg.sv
rtl/bmhpq_ram.sv
rtl/binary_max_heap_priority_queue.sv
sim/binary_max_heap_priority_queue_tb.sv
